// ----- sv/pfba_pkg.sv -----
// Shared types and constants for the page frame bitmap allocator.
// Holds the request and result transaction structs, opcodes and status codes.
// Depends on nothing.
package pfba_pkg;

    localparam int PAGES_DEF         = 4096;
    localparam int MAP_WORD_BITS_DEF = 32;
    localparam int SUM_BITS          = 32;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NONE_FREE    = 3'd1;
    localparam logic [2:0] ST_RANGE        = 3'd2;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [2:0] ST_ALREADY_USED = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] page_number;
    } t_req;

    typedef struct packed {
        logic [11:0] allocated_page;
        logic [2:0]  status;
        logic [12:0] free_count;
    } t_rsp;

endpackage

// ----- sv/pfba_ffs.sv -----
// Find-first-set unit: index of the lowest set bit of a vector.
// Used for the summary words and the map words. Depends on nothing.
module pfba_ffs #(
    parameter int W = 32
) (
    input  logic [W-1:0]                   i_vec,
    output logic                           o_found,
    output logic [(W > 1 ? $clog2(W) : 1)-1:0] o_idx
);

    localparam int IW = (W > 1) ? $clog2(W) : 1;

    assign o_found = |i_vec;

    always_comb begin
        o_idx = '0;
        for (int k = W - 1; k >= 0; k--) begin
            if (i_vec[k]) begin
                o_idx = IW'(k);
            end
        end
    end

endmodule

// ----- sv/page_frame_bitmap_allocator.sv -----
// Page frame bitmap allocator: free map memory, summary memory and control.
// Depends on pfba_pkg and pfba_ffs.
//
// Requests arrive on the input channel (i_in_valid, o_in_ready, i_in_data) and
// each produces exactly one result on the output channel (o_out_valid,
// i_out_ready, o_out_data). Allocate grants the lowest free page, free and
// reserve change one page; every result carries a status and the free count.
// The free map lives in one memory of one bit per page, and a second memory
// holds one bit per map word that is set while that word has a free page.
// Requests are handled one at a time. Free and reserve pass through the divide,
// read and modify states; allocate reads summary words in turn, skipping empty
// ones, then updates the map word; requests that fail before touching the
// memories go straight to the final state. The next request is taken in the
// cycle after the result is registered, even while that result still waits.
// If the receiver stalls, a finished result waits in the final state until the
// output register is free. After reset the block sweeps both memories to zero,
// one map word per cycle, and accepts nothing until the sweep is done; then
// every page is used.
module page_frame_bitmap_allocator #(
    parameter int PAGES         = pfba_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pfba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfba_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pfba_pkg::t_rsp o_out_data
);
    import pfba_pkg::*;

    localparam int D         = MAP_WORD_BITS;
    localparam int PW        = $clog2(PAGES);
    localparam int MAP_WORDS = (PAGES + D - 1) / D;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(D);
    localparam int SUM_WORDS = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
    localparam int SW        = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int SIW       = $clog2(SUM_WORDS + 1);
    localparam int SBW       = $clog2(SUM_BITS);
    localparam int CW        = $clog2(PAGES + 1);
    localparam int DS        = PW + 7;
    localparam int MW        = PW + DS;
    localparam longint unsigned RECIP = ((64'd1 << DS) + D - 1) / D;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_RD, S_MOD, S_SCAN, S_SCHK, S_AMOD, S_FIN
    } t_state;

    t_state         r_state, n_state;
    logic [WW-1:0]  r_clr, n_clr;
    logic [1:0]     r_op, n_op;
    logic [PW-1:0]  r_page, n_page;
    logic [WW-1:0]  r_word, n_word;
    logic [BW-1:0]  r_bit, n_bit;
    logic [SIW-1:0] r_sidx, n_sidx;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [2:0]     r_status, n_status;
    logic [PW-1:0]  r_grant, n_grant;
    logic           r_out_valid, n_out_valid;
    t_rsp           r_out, n_out;

    logic [D-1:0]        map_mem [MAP_WORDS];
    logic [SUM_BITS-1:0] sum_mem [SUM_WORDS];
    logic [D-1:0]        r_map_q;
    logic [SUM_BITS-1:0] r_sum_q;

    logic                map_re, map_we, sum_re, sum_we;
    logic [WW-1:0]       map_ra, map_wa;
    logic [SW-1:0]       sum_ra, sum_wa;
    logic [D-1:0]        map_wd;
    logic [SUM_BITS-1:0] sum_wd;

    logic                map_found, sum_found;
    logic [BW-1:0]       map_low;
    logic [SBW-1:0]      sum_low;
    logic [MW-1:0]       q_prod;
    logic [SW-1:0]       word_sidx;
    logic [SUM_BITS-1:0] smask;
    logic [D-1:0]        bmask, amask, map_set, map_clr, map_alloc;
    logic                in_range;

    pfba_ffs #(.W(D)) u_ffs_map (
        .i_vec   (r_map_q),
        .o_found (map_found),
        .o_idx   (map_low)
    );

    pfba_ffs #(.W(SUM_BITS)) u_ffs_sum (
        .i_vec   (r_sum_q),
        .o_found (sum_found),
        .o_idx   (sum_low)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_range  = (32'(i_in_data.page_number) < PAGES);
    assign q_prod    = MW'(r_page) * MW'(RECIP);
    assign word_sidx = SW'(r_word >> SBW);
    assign smask     = SUM_BITS'(1) << SBW'(r_word);
    assign bmask     = D'(1) << r_bit;
    assign amask     = D'(1) << map_low;
    assign map_set   = r_map_q | bmask;
    assign map_clr   = r_map_q & ~bmask;
    assign map_alloc = r_map_q & ~amask;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_page      = r_page;
        n_word      = r_word;
        n_bit       = r_bit;
        n_sidx      = r_sidx;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_grant     = r_grant;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        map_re      = 1'b0;
        map_we      = 1'b0;
        sum_re      = 1'b0;
        sum_we      = 1'b0;
        map_ra      = r_word;
        map_wa      = r_word;
        map_wd      = '0;
        sum_ra      = word_sidx;
        sum_wa      = word_sidx;
        sum_wd      = '0;

        case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                if (32'(r_clr) < SUM_WORDS) begin
                    sum_we = 1'b1;
                    sum_wa = SW'(r_clr);
                end
                if (r_clr == WW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.opcode;
                    n_page   = PW'(i_in_data.page_number);
                    n_grant  = '0;
                    n_status = ST_OK;
                    n_sidx   = '0;
                    case (i_in_data.opcode)
                        OP_ALLOC: begin
                            if (r_cnt == '0) begin
                                n_status = ST_NONE_FREE;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_FREE, OP_RESERVE: begin
                            if (!in_range) begin
                                n_status = ST_RANGE;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_word  = WW'(q_prod >> DS);
                n_state = S_RD;
            end
            S_RD: begin
                n_bit   = BW'(r_page - PW'(r_word * D));
                map_re  = 1'b1;
                sum_re  = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = S_FIN;
                if (r_op == OP_FREE) begin
                    if (r_map_q[r_bit]) begin
                        n_status = ST_ALREADY_FREE;
                    end else begin
                        map_we = 1'b1;
                        map_wd = map_set;
                        sum_we = 1'b1;
                        sum_wd = r_sum_q | smask;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end else begin
                    if (!r_map_q[r_bit]) begin
                        n_status = ST_ALREADY_USED;
                    end else begin
                        map_we = 1'b1;
                        map_wd = map_clr;
                        if (map_clr == '0) begin
                            sum_we = 1'b1;
                            sum_wd = r_sum_q & ~smask;
                        end
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_SCAN: begin
                sum_re  = 1'b1;
                sum_ra  = SW'(r_sidx);
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (sum_found) begin
                    n_word  = WW'({r_sidx, sum_low});
                    map_re  = 1'b1;
                    map_ra  = WW'({r_sidx, sum_low});
                    n_state = S_AMOD;
                end else if (r_sidx == SIW'(SUM_WORDS - 1)) begin
                    n_status = ST_NONE_FREE;
                    n_state  = S_FIN;
                end else begin
                    n_sidx  = r_sidx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_AMOD: begin
                n_state = S_FIN;
                if (map_found) begin
                    n_grant = PW'(r_word * D + map_low);
                    map_we  = 1'b1;
                    map_wd  = map_alloc;
                    if (map_alloc == '0) begin
                        sum_we = 1'b1;
                        sum_wd = r_sum_q & ~smask;
                    end
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_status = ST_NONE_FREE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.allocated_page = 12'(r_grant);
                    n_out.status         = r_status;
                    n_out.free_count     = 13'(r_cnt);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_page   <= n_page;
        r_word   <= n_word;
        r_bit    <= n_bit;
        r_sidx   <= n_sidx;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= map_mem[map_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (sum_re) begin
            r_sum_q <= sum_mem[sum_ra];
        end
    end

endmodule

// ----- sv/pfba_checker.sv -----
// Port-level checks for the page frame bitmap allocator, bound to its top level.
// Depends on pfba_pkg and page_frame_bitmap_allocator.
module pfba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pfba_pkg::t_rsp o_out_data
);
    import pfba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result changed while stalled.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_NONE_FREE
            || o_out_data.status == ST_RANGE || o_out_data.status == ST_ALREADY_FREE
            || o_out_data.status == ST_ALREADY_USED))
        else $error("Unknown status code.");

    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.allocated_page == '0)
        else $error("Failed request reports a page.");

    a_none_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NONE_FREE |-> o_out_data.free_count == '0)
        else $error("No free page reported with a nonzero count.");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- bench/tb.sv -----
// Self-checking bench for page_frame_bitmap_allocator: a table of requests, then random
// allocate, free and reserve traffic, checked against table rows or a free-map model.
// Depends on pfba_pkg and the allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfba_pkg::*;

    localparam int PAGES      = PAGES_DEF;
    localparam int WORD_BITS  = MAP_WORD_BITS_DEF;
    localparam int MAP_WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int DIR_N      = 24;
    localparam int RAND_N     = 1530;
    localparam int QUIET_MAX  = 3000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int STEADY_LO  = 700;
    localparam int STEADY_HI  = 1000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    t_req i_in_data  = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    logic [WORD_BITS-1:0] free_words [MAP_WORDS];
    logic [12:0]          free_total;
    t_rsp                 rsp_due [$];
    int                   err_cnt  = 0;
    int                   sent_cnt = 0;
    bit                   steady   = 1'b0;

    t_dir_row dir_tab [DIR_N] = '{
        '{'{OP_ALLOC,   12'd0},    1'b1, '{12'd0,    ST_NONE_FREE,    13'd0}},
        '{'{OP_RESERVE, 12'd0},    1'b1, '{12'd0,    ST_ALREADY_USED, 13'd0}},
        '{'{OP_RESERVE, 12'd4095}, 1'b1, '{12'd0,    ST_ALREADY_USED, 13'd0}},
        '{'{OP_UNUSED,  12'hFFF},  1'b1, '{12'd0,    ST_OK,           13'd0}},
        '{'{OP_FREE,    12'd4095}, 1'b1, '{12'd0,    ST_OK,           13'd1}},
        '{'{OP_FREE,    12'd4095}, 1'b1, '{12'd0,    ST_ALREADY_FREE, 13'd1}},
        '{'{OP_ALLOC,   12'hFFF},  1'b1, '{12'd4095, ST_OK,           13'd0}},
        '{'{OP_FREE,    12'd0},    1'b1, '{12'd0,    ST_OK,           13'd1}},
        '{'{OP_FREE,    12'd31},   1'b0, '0},
        '{'{OP_FREE,    12'd32},   1'b0, '0},
        '{'{OP_FREE,    12'h800},  1'b0, '0},
        '{'{OP_FREE,    12'hAAA},  1'b0, '0},
        '{'{OP_FREE,    12'h555},  1'b0, '0},
        '{'{OP_ALLOC,   12'h555},  1'b0, '0},
        '{'{OP_RESERVE, 12'd31},   1'b0, '0},
        '{'{OP_RESERVE, 12'd31},   1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b1, '{12'd0,    ST_NONE_FREE,    13'd0}},
        '{'{OP_FREE,    12'd1023}, 1'b0, '0},
        '{'{OP_ALLOC,   12'd0},    1'b0, '0},
        '{'{OP_UNUSED,  12'h000},  1'b0, '0}
    };

    page_frame_bitmap_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_rsp page_map_step(input t_req req);
        t_rsp rsp;
        int   found;
        int   w;
        int   b;
        rsp   = '0;
        found = -1;
        case (req.opcode)
            OP_ALLOC: begin
                for (w = 0; w < MAP_WORDS && found < 0; w++) begin
                    for (b = 0; b < WORD_BITS && found < 0; b++) begin
                        if (free_words[w][b] && w * WORD_BITS + b < PAGES) begin
                            found = w * WORD_BITS + b;
                        end
                    end
                end
                if (free_total == 0 || found < 0) begin
                    rsp.status = ST_NONE_FREE;
                end else begin
                    free_words[found / WORD_BITS][found % WORD_BITS] = 1'b0;
                    free_total         = free_total - 1'b1;
                    rsp.allocated_page = 12'(found);
                end
            end
            OP_FREE, OP_RESERVE: begin
                w = int'(req.page_number) / WORD_BITS;
                b = int'(req.page_number) % WORD_BITS;
                if (int'(req.page_number) >= PAGES) begin
                    rsp.status = ST_RANGE;
                end else if (req.opcode == OP_FREE) begin
                    if (free_words[w][b]) begin
                        rsp.status = ST_ALREADY_FREE;
                    end else begin
                        free_words[w][b] = 1'b1;
                        free_total       = free_total + 1'b1;
                    end
                end else if (!free_words[w][b]) begin
                    rsp.status = ST_ALREADY_USED;
                end else begin
                    free_words[w][b] = 1'b0;
                    free_total       = free_total - 1'b1;
                end
            end
            default: begin
            end
        endcase
        rsp.free_count = free_total;
        return rsp;
    endfunction

    // Random pages lean toward both ends of the map so word and summary edges get hit.
    function automatic logic [11:0] pick_page(input bit want_free);
        int r;
        int p;
        int k;
        r = $urandom_range(99);
        if (r < 50) begin
            p = $urandom_range(4095);
        end else if (r < 80) begin
            p = $urandom_range(95);
        end else begin
            p = $urandom_range(4095, 4000);
        end
        if (want_free) begin
            for (k = 0; k < PAGES; k++) begin
                if (free_words[((p + k) % PAGES) / WORD_BITS][((p + k) % PAGES) % WORD_BITS]) begin
                    return 12'((p + k) % PAGES);
                end
            end
        end
        return 12'(p);
    endfunction

    function automatic t_req pick_request();
        t_req req;
        int   r;
        r = $urandom_range(99);
        req.page_number = 12'($urandom);
        if (r < 36) begin
            req.opcode      = OP_FREE;
            req.page_number = pick_page(1'b0);
        end else if (r < 66) begin
            req.opcode = OP_ALLOC;
        end else if (r < 76) begin
            req.opcode      = OP_RESERVE;
            req.page_number = pick_page(1'b1);
        end else if (r < 86) begin
            req.opcode      = OP_RESERVE;
            req.page_number = pick_page(1'b0);
        end else if (r < 94) begin
            req.opcode      = OP_FREE;
            req.page_number = pick_page(1'b1);
        end else begin
            req.opcode = OP_UNUSED;
        end
        return req;
    endfunction

    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (rsp_due.size() == 0) begin
            $display("%0t ns: result with none expected: expected none, actual %p", $time, got);
            err_cnt++;
        end else begin
            want = rsp_due.pop_front();
            if (got.allocated_page !== want.allocated_page) begin
                $display("%0t ns: allocated_page expected %0d actual %0d",
                         $time, want.allocated_page, got.allocated_page);
                err_cnt++;
            end
            if (got.status !== want.status) begin
                $display("%0t ns: status expected %0d actual %0d", $time, want.status, got.status);
                err_cnt++;
            end
            if (got.free_count !== want.free_count) begin
                $display("%0t ns: free_count expected %0d actual %0d",
                         $time, want.free_count, got.free_count);
                err_cnt++;
            end
        end
    endtask

    initial begin
        int   hold_left;
        bit   hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result(o_out_data);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || $urandom_range(99) >= 32;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_req req;
        t_rsp pred;
        int   idx;
        for (idx = 0; idx < MAP_WORDS; idx++) begin
            free_words[idx] = '0;
        end
        free_total = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (idx = 0; idx < DIR_N + RAND_N; idx++) begin
            steady = idx >= STEADY_LO && idx < STEADY_HI;
            req = (idx < DIR_N) ? dir_tab[idx].req : pick_request();
            if (!steady) begin
                while ($urandom_range(99) < 32) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_in_data  <= req;
            do @(posedge i_clk); while (!o_in_ready);
            pred = page_map_step(req);
            if (idx < DIR_N && dir_tab[idx].typed) begin
                rsp_due.push_back(dir_tab[idx].rsp);
            end else begin
                rsp_due.push_back(pred);
            end
            sent_cnt++;
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
